// File: rtl/core/wto_pkg.sv
// ----------------------------------------------------------------------------
// wto_pkg
// Shared types and constants of the wavetable oscillator.
// ----------------------------------------------------------------------------
package wto_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_NOTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] REG_LENGTH = 2'd0;
    localparam logic [CFG_IW-1:0] REG_INTERP = 2'd1;
    localparam logic [CFG_IW-1:0] REG_GAIN   = 2'd2;

    localparam int LENGTH_W = 9;
    localparam int GAIN_W   = 24;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 16;
    localparam int STEP_W   = 24;
    localparam int SAMPLE_W = 16;
    localparam int CFG_DW   = 24;

    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 9'd128;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd65536;
    localparam int LENGTH_MIN = 4;
    localparam int GAIN_FRAC  = 16;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    localparam int QDEPTH = 4;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_NOTE  = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic [INDEX_W-1:0]         index;
        logic signed [VALUE_W-1:0]  value;
        logic [STEP_W-1:0]          step;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_slot_t;

    typedef struct packed {
        logic [LENGTH_W-1:0] length;
        logic                interp;
        logic [GAIN_W-1:0]   gain;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_MOD = 2'b10
    } back_state_t;

endpackage

// File: rtl/core/wavetable_oscillator.sv
// ----------------------------------------------------------------------------
// wavetable_oscillator
// Wavetable oscillator with nearest-entry or linear interpolated readout,
// output gain and saturation.
//
//   Channel   Handshake                      Content
//   s_axis    s_axis_tvalid/s_axis_tready    tuser: op; tdata: entry_index,
//                                            entry_value, phase_step
//   m_axis    m_axis_tvalid/m_axis_tready    tdata: sample
//   cfg       cfg_we                         cfg_index selects table_length,
//                                            interpolate or gain
//
// One beat is taken per cycle while s_axis_tready is high; a tick's sample
// passes the decode stage, the queue and the five-stage datapath.
// A tick that finds the phase at or above twice the table length, possible
// only after the length was lowered, is held while a restoring remainder
// loop reduces the phase, one quotient bit at a time, before it is taken.
// The table has no clearing pass after reset.
// A stalled m_axis freezes the datapath; the queue and decode stage hold
// five more beats before s_axis_tready falls.
// ----------------------------------------------------------------------------
module wavetable_oscillator #(
    parameter int TABLE_DEPTH = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [47:0]                   s_axis_tdata,  // entry_index, entry_value, phase_step
    input  logic [1:0]                    s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // sample
    input  logic                          cfg_we,
    input  logic [wto_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [wto_pkg::CFG_DW-1:0]    cfg_wdata
);
    import wto_pkg::*;

    cfg_t       cfg_reg;
    cmd_slot_t  push;
    logic       push_ready;
    cmd_slot_t  head;
    logic       pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.length <= LENGTH_RESET;
            cfg_reg.interp <= 1'b0;
            cfg_reg.gain   <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LENGTH: cfg_reg.length <= cfg_wdata[LENGTH_W-1:0];
                REG_INTERP: cfg_reg.interp <= cfg_wdata[0];
                REG_GAIN:   cfg_reg.gain   <= cfg_wdata[GAIN_W-1:0];
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    wto_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_user    (s_axis_tuser),
        .push       (push),
        .push_ready (push_ready)
    );

    wto_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    wto_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// File: rtl/core/wto_front.sv
// ----------------------------------------------------------------------------
// wto_front
// Input stage: takes beats, decodes them into commands and drops the ones
// that have no effect.
// ----------------------------------------------------------------------------
module wto_front #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [47:0]           in_data,
    input  logic [1:0]            in_user,
    output wto_pkg::cmd_slot_t    push,
    input  logic                  push_ready
);
    import wto_pkg::*;

    logic       slot_valid_reg;
    cmd_t       cmd_reg;
    cmd_t       cmd_dec;
    logic       keep;
    logic       in_range;
    logic       accept;

    assign in_range = {24'd0, in_data[7:0]} < 32'(TABLE_DEPTH);
    assign in_ready = !slot_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd_dec.index = in_data[7:0];
        cmd_dec.value = $signed(in_data[23:8]);
        cmd_dec.step  = in_data[47:24];
        case (in_user)
            OP_WRITE:
            begin
                cmd_dec.kind = CMD_WRITE;
                keep         = in_range;
            end
            OP_NOTE:
            begin
                cmd_dec.kind = CMD_NOTE;
                keep         = 1'b1;
            end
            OP_TICK:
            begin
                cmd_dec.kind = CMD_TICK;
                keep         = 1'b1;
            end
            default:
            begin
                cmd_dec.kind = CMD_NOTE;
                keep         = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            slot_valid_reg <= keep;
        end
        else if (push_ready)
        begin
            slot_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_dec;
        end
    end

    assign push.valid = slot_valid_reg;
    assign push.cmd   = cmd_reg;

endmodule

// File: rtl/core/wto_queue.sv
// ----------------------------------------------------------------------------
// wto_queue
// Short command queue between the decode stage and the execution stage.
// ----------------------------------------------------------------------------
module wto_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wto_pkg::cmd_slot_t    push,
    output logic                  push_ready,
    output wto_pkg::cmd_slot_t    head,
    input  logic                  pop
);
    import wto_pkg::*;

    localparam int QAW = $clog2(QDEPTH);

    cmd_t             mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic [QAW:0]     count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != (QAW+1)'(QDEPTH);
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QAW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    assign head.valid = count_reg != '0;
    assign head.cmd   = mem_reg[rd_ptr_reg];

endmodule

// File: rtl/core/wto_back.sv
// ----------------------------------------------------------------------------
// wto_back
// Execution stage: wave table memory, phase accumulator with wrap, and the
// interpolation and gain pipeline that feeds the output register.
// ----------------------------------------------------------------------------
module wto_back #(
    parameter int TABLE_DEPTH = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wto_pkg::cfg_t                 cfg,
    input  wto_pkg::cmd_slot_t            head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [wto_pkg::SAMPLE_W-1:0]  out_data
);
    import wto_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = AW + 1;
    localparam int LW = AW + 1;
    localparam int PW = IW + FRAC_BITS;
    localparam int SW = (PW > STEP_W) ? PW : STEP_W;
    localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int CW = (LW > LENGTH_W) ? LW : LENGTH_W;
    localparam int DW = LW + IW - 1;
    localparam int KW = $clog2(IW);
    localparam int VW = VALUE_W + 1;
    localparam int MW = VW + FRAC_BITS + 1;
    localparam int GW = VW + GAIN_W + 1;

    // Used table length, clamped to the legal range.
    logic [CW-1:0]  len_ext;
    logic [CW-1:0]  len_c;
    logic [LW-1:0]  len;
    logic [PW-1:0]  limit;

    always_comb
    begin
        len_ext = CW'(cfg.length);
        if (len_ext < CW'(LENGTH_MIN))
        begin
            len_c = CW'(LENGTH_MIN);
        end
        else if (len_ext > CW'(TABLE_DEPTH))
        begin
            len_c = CW'(TABLE_DEPTH);
        end
        else
        begin
            len_c = len_ext;
        end
        len   = len_c[LW-1:0];
        limit = {len, {FRAC_BITS{1'b0}}};
    end

    back_state_t    state_reg;
    back_state_t    state_next;
    logic [PW-1:0]  phase_reg;
    logic [PW-1:0]  phase_next;
    logic [DW-1:0]  div_reg;
    logic [DW-1:0]  div_next;
    logic [KW-1:0]  k_reg;
    logic [KW-1:0]  k_next;

    logic           en;
    logic [IW-1:0]  int_part;
    logic           need_mod;
    logic [PW-1:0]  wrapped;
    logic [IW-1:0]  a_int;
    logic [AW-1:0]  addr_a;
    logic [AW-1:0]  addr_b;
    logic [SW-1:0]  step_e;
    logic [SW-1:0]  step_sat;
    logic [PW-1:0]  phase_adv;
    logic [DW-1:0]  int_e;
    logic [DW-1:0]  int_sub;
    logic [XW-1:0]  waddr_e;
    logic           do_write;
    logic           do_tick;

    assign en       = !out_valid || out_ready;
    assign int_part = phase_reg[PW-1:FRAC_BITS];
    assign need_mod = {1'b0, int_part} >= {len, 1'b0};
    assign wrapped  = (int_part >= len) ? (phase_reg - limit) : phase_reg;
    assign a_int    = wrapped[PW-1:FRAC_BITS];
    assign addr_a   = a_int[AW-1:0];
    assign addr_b   = ((a_int + IW'(1)) == len) ? '0 : (addr_a + AW'(1));
    assign step_e   = SW'(head.cmd.step);
    assign step_sat = (step_e >= SW'(limit)) ? (SW'(limit) - SW'(1)) : step_e;
    assign phase_adv = wrapped + step_sat[PW-1:0];
    assign int_e    = DW'(int_part);
    assign int_sub  = int_e - div_reg;
    assign waddr_e  = XW'(head.cmd.index);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        div_next   = div_reg;
        k_next     = k_reg;
        pop        = 1'b0;
        do_write   = 1'b0;
        do_tick    = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                if (en && head.valid)
                begin
                    case (head.cmd.kind)
                        CMD_WRITE:
                        begin
                            do_write = 1'b1;
                            pop      = 1'b1;
                        end
                        CMD_NOTE:
                        begin
                            phase_next = '0;
                            pop        = 1'b1;
                        end
                        CMD_TICK:
                        begin
                            if (need_mod)
                            begin
                                state_next = ST_MOD;
                                div_next   = {len, {(IW-1){1'b0}}};
                                k_next     = KW'(IW - 1);
                            end
                            else
                            begin
                                do_tick    = 1'b1;
                                phase_next = phase_adv;
                                pop        = 1'b1;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                // Restoring remainder of the integer phase, one quotient bit a cycle.
                if (int_e >= div_reg)
                begin
                    phase_next = {int_sub[IW-1:0], phase_reg[FRAC_BITS-1:0]};
                end
                div_next = div_reg >> 1;
                k_next   = k_reg - KW'(1);
                if (k_reg == '0)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            phase_reg <= '0;
            div_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            div_reg   <= div_next;
            k_reg     <= k_next;
        end
    end

    logic signed [VALUE_W-1:0] table_mem [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] rda_reg;
    logic signed [VALUE_W-1:0] rdb_reg;

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            table_mem[waddr_e[AW-1:0]] <= head.cmd.value;
        end
        if (en)
        begin
            rda_reg <= table_mem[addr_a];
            rdb_reg <= table_mem[addr_b];
        end
    end

    logic                       v1_reg;
    logic                       v2_reg;
    logic                       v3_reg;
    logic                       v4_reg;
    logic                       out_valid_reg;
    logic [FRAC_BITS-1:0]       frac1_reg;
    logic signed [VALUE_W-1:0]  sa2_reg;
    logic signed [MW-1:0]       prod2_reg;
    logic signed [VW-1:0]       val3_reg;
    logic signed [GW-1:0]       gprod4_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;

    logic signed [VW-1:0]       diff;
    logic signed [MW-1:0]       diff_w;
    logic signed [MW-1:0]       frac_w;
    logic signed [MW-1:0]       prod_sum;
    logic signed [MW-1:0]       prod_rnd;
    logic signed [VW-1:0]       val;
    logic signed [GW-1:0]       val_w;
    logic signed [GW-1:0]       gain_w;
    logic signed [GW-1:0]       g_sum;
    logic signed [GW-1:0]       g_rnd;
    logic [SAMPLE_W-1:0]        sat;

    always_comb
    begin
        diff     = VW'(rdb_reg) - VW'(rda_reg);
        diff_w   = MW'(diff);
        frac_w   = MW'($signed({1'b0, frac1_reg}));
        prod_sum = prod2_reg + (MW'(1) <<< (FRAC_BITS - 1));
        prod_rnd = prod_sum >>> FRAC_BITS;
        if (cfg.interp)
        begin
            val = VW'(sa2_reg) + prod_rnd[VW-1:0];
        end
        else
        begin
            val = VW'(sa2_reg);
        end
        val_w  = GW'(val3_reg);
        gain_w = GW'($signed({1'b0, cfg.gain}));
        g_sum  = gprod4_reg + (GW'(1) <<< (GAIN_FRAC - 1));
        g_rnd  = g_sum >>> GAIN_FRAC;
        if (g_rnd > GW'(SAMPLE_MAX))
        begin
            sat = SAMPLE_W'(SAMPLE_MAX);
        end
        else if (g_rnd < GW'(SAMPLE_MIN))
        begin
            sat = SAMPLE_W'(SAMPLE_MIN);
        end
        else
        begin
            sat = g_rnd[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= do_tick;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frac1_reg    <= wrapped[FRAC_BITS-1:0];
            sa2_reg      <= rda_reg;
            prod2_reg    <= diff_w * frac_w;
            val3_reg     <= val;
            gprod4_reg   <= val_w * gain_w;
            out_data_reg <= sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/core/wto_checker.sv
// ----------------------------------------------------------------------------
// wto_checker
// Port-level checks of the wavetable oscillator, bound to the top level.
// ----------------------------------------------------------------------------
module wto_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata
);
    import wto_pkg::*;

    // Decode stage, queue, four datapath stages and the output register.
    localparam int PENDING_MAX = QDEPTH + 6;

    logic [4:0] pending_reg;
    logic       tick_in;
    logic       beat_out;

    assign tick_in  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_TICK);
    assign beat_out = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (tick_in && !beat_out)
        begin
            pending_reg <= pending_reg + 5'd1;
        end
        else if (beat_out && !tick_in)
        begin
            pending_reg <= pending_reg - 5'd1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("sample beat changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 5'd0)
        else $error("sample beat without a pending tick");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 5'(PENDING_MAX))
        else $error("more ticks pending than the design can hold");

endmodule

bind wavetable_oscillator wto_checker u_wto_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: test/wavetable_oscillator_tb.sv
// ----------------------------------------------------------------------------
// wavetable_oscillator_tb
// Self-checking bench for the wavetable oscillator: table loads, note starts
// and ticks stream in, each sample is predicted from a behavioral model of
// the phase walk, interpolation, gain and saturation, and compared in order.
// ----------------------------------------------------------------------------
module wavetable_oscillator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wto_pkg::*;

    localparam logic [1:0]        OP_UNUSED = 2'd3;
    localparam logic [CFG_IW-1:0] REG_NONE  = 2'd3;
    localparam int                DEPTH     = 256;
    localparam int                PHASES    = 10;
    localparam int                PER_PHASE = 100;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         index;
        logic signed [15:0] value;
        logic [23:0]        step;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;

    beat_t       item_q[$];
    logic [15:0] sample_q[$];
    bit          loaded[DEPTH];
    bit          beat_taken = 1'b0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          mismatches = 0;
    int          beats_in = 0;
    int          samples_seen = 0;
    int          reg_writes = 0;

    // Behavioral copy of the oscillator state.
    logic signed [15:0] wave_mem[DEPTH];
    longint             acc_phase = 0;
    logic [8:0]         len_reg = LENGTH_RESET;
    logic               interp_reg = 1'b0;
    logic [23:0]        gain_reg = GAIN_RESET;

    wavetable_oscillator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic int used_length();
        if (len_reg < LENGTH_MIN)
            return LENGTH_MIN;
        if (len_reg > DEPTH)
            return DEPTH;
        return int'(len_reg);
    endfunction

    function automatic bit oscillator_sample(input beat_t b, output logic [15:0] smp);
        longint len;
        longint limit;
        longint a;
        longint nxt;
        longint frac;
        longint sa;
        longint sb;
        longint val;
        longint scaled;
        longint step;
        smp = '0;
        if (b.op == OP_WRITE)
        begin
            wave_mem[b.index] = b.value;
            return 1'b0;
        end
        if (b.op == OP_NOTE)
        begin
            acc_phase = 0;
            return 1'b0;
        end
        if (b.op != OP_TICK)
            return 1'b0;
        len   = used_length();
        limit = len << 16;
        if (acc_phase >= limit)
            acc_phase = acc_phase % limit;
        a    = acc_phase >> 16;
        frac = acc_phase & 64'hFFFF;
        sa   = wave_mem[a];
        if (interp_reg)
        begin
            nxt = (a < len - 1) ? a + 1 : 0;
            sb  = wave_mem[nxt];
            val = sa + (((sb - sa) * frac + 32768) >>> 16);
        end
        else
            val = sa;
        scaled = (val * longint'(gain_reg) + 32768) >>> GAIN_FRAC;
        if (scaled > SAMPLE_MAX)
            scaled = SAMPLE_MAX;
        if (scaled < SAMPLE_MIN)
            scaled = SAMPLE_MIN;
        step = longint'(b.step);
        if (step >= limit)
            step = limit - 1;
        acc_phase = acc_phase + step;
        smp = scaled[15:0];
        return 1'b1;
    endfunction

    // Driver: a new beat goes out on the falling edge once the last one was taken.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || beat_taken)
        begin
            if (item_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                beat_t b;
                b = item_q.pop_front();
                s_axis_tuser  <= b.op;
                s_axis_tdata  <= {b.step, b.value, b.index};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: predicts on every accepted input beat and checks every sample.
    always @(posedge clk)
    begin
        beat_t       b;
        logic [15:0] smp;
        logic [15:0] want;
        beat_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            b.op    = s_axis_tuser;
            b.index = s_axis_tdata[7:0];
            b.value = s_axis_tdata[23:8];
            b.step  = s_axis_tdata[47:24];
            beats_in++;
            if (oscillator_sample(b, smp))
                sample_q.push_back(smp);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            samples_seen++;
            if (sample_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: sample %h with none expected", $realtime, m_axis_tdata);
            end
            else
            begin
                want = sample_q.pop_front();
                if (m_axis_tdata !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: sample expected %h actual %h",
                                 $realtime, want, m_axis_tdata);
                end
            end
        end
    end

    task automatic push_item(input logic [1:0] op, input int idx, input int val,
                             input int unsigned step);
        beat_t b;
        b.op    = op;
        b.index = idx[7:0];
        b.value = val[15:0];
        b.step  = step[23:0];
        if (op == OP_WRITE)
            loaded[b.index] = 1'b1;
        item_q.push_back(b);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input int unsigned data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data[CFG_DW-1:0];
        case (idx)
            REG_LENGTH: len_reg    = data[8:0];
            REG_INTERP: interp_reg = data[0];
            REG_GAIN:   gain_reg   = data[23:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (item_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (sample_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
            default: begin src_idle_pct = 23; sink_stall_pct = 23; end
        endcase
    endtask

    task automatic load_table(input int len);
        for (int i = 0; i < len; i++)
            if (!loaded[i])
                push_item(OP_WRITE, i, $urandom, $urandom);
    endtask

    task automatic random_item(input int len);
        int unsigned limit;
        int unsigned step;
        int          r;
        limit = len << 16;
        r = $urandom_range(99);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: step = $urandom_range(limit / 4);
            5, 6:          step = $urandom_range(limit - 1);
            7:             step = limit - 1;
            8:             step = limit;
            default:       step = $urandom;
        endcase
        if (r < 70)
            push_item(OP_TICK, $urandom_range(255), $urandom, step);
        else if (r < 84)
            push_item(OP_WRITE, $urandom_range(255), $urandom, $urandom);
        else if (r < 94)
            push_item(OP_NOTE, $urandom_range(255), $urandom, $urandom);
        else
            push_item(OP_UNUSED, $urandom_range(255), $urandom, $urandom);
    endtask

    initial
    begin
        int lengths[6];
        int len;
        lengths = '{511, 5, 257, 0, 1, 4};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Four-entry table with the value extremes, nearest readout.
        write_reg(REG_LENGTH, 3);
        write_reg(REG_INTERP, 0);
        write_reg(REG_GAIN, 65536);
        push_item(OP_WRITE, 0, 32767, 0);
        push_item(OP_WRITE, 1, -32768, 0);
        push_item(OP_WRITE, 2, 0, 0);
        push_item(OP_WRITE, 3, -1, 0);
        push_item(OP_WRITE, 255, 16'h5A5A, 24'hFFFFFF);
        push_item(OP_UNUSED, 255, -1, 24'hFFFFFF);
        push_item(OP_NOTE, 0, 0, 0);
        push_item(OP_TICK, 0, 0, 0);
        push_item(OP_TICK, 0, 0, 24'h010000);
        push_item(OP_TICK, 0, 0, 24'h018000);
        push_item(OP_TICK, 0, 0, 24'hFFFFFF);
        push_item(OP_TICK, 0, 0, 24'h008000);
        push_item(OP_NOTE, 0, 0, 0);
        push_item(OP_TICK, 0, 0, 0);
        drain();

        // Interpolation across the last entry back to the first, full-scale gain.
        write_reg(REG_INTERP, 1);
        write_reg(REG_GAIN, 24'hFFFFFF);
        write_reg(REG_NONE, $urandom);
        for (int i = 0; i < 5; i++)
            push_item(OP_TICK, 0, 0, 24'h00C000);
        drain();
        write_reg(REG_GAIN, 0);
        push_item(OP_TICK, 0, 0, 24'h003000);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            set_idling(p);
            if (p < 6)
                write_reg(REG_LENGTH, lengths[p]);
            else
                write_reg(REG_LENGTH, $urandom_range(256, 4));
            write_reg(REG_INTERP, (p < 6) ? (p % 2) : $urandom_range(1));
            case (p % 5)
                0:       write_reg(REG_GAIN, 65536);
                1:       write_reg(REG_GAIN, 24'hFFFFFF);
                2:       write_reg(REG_GAIN, 0);
                3:       write_reg(REG_GAIN, $urandom_range(131072));
                default: write_reg(REG_GAIN, $urandom_range(24'hFFFFFF));
            endcase
            if (p == 7)
                write_reg(REG_NONE, $urandom);
            len = used_length();
            load_table(len);
            for (int i = 0; i < PER_PHASE; i++)
                random_item(len);
            drain();
        end

        $display("Input beats: %0d, samples checked: %0d, register writes: %0d",
                 beats_in, samples_seen, reg_writes);
        $display("Table lengths from below the minimum to above the depth, both readout modes.");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/wto_pkg.sv
rtl/core/wto_front.sv
rtl/core/wto_queue.sv
rtl/core/wto_back.sv
rtl/core/wavetable_oscillator.sv
rtl/core/wto_checker.sv
test/wavetable_oscillator_tb.sv
